@@ rtl/dwsa_pkg.sv @@
// shared types and constants for the diamond window sum and argmax block
`default_nettype none

package dwsa_pkg;

    localparam int ROW_LIMIT  = 1024;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int RAD_CFG_W  = 4;
    localparam int POS_W      = 11;
    localparam int SUM_W      = 25;
    localparam int CNT_W      = 21;
    localparam int EV_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

    localparam logic [EV_W-1:0] EV_BELOW = 2'd0;
    localparam logic [EV_W-1:0] EV_NEW   = 2'd1;
    localparam logic [EV_W-1:0] EV_TIE   = 2'd2;

    typedef struct packed {
        logic accept;
        logic center_init;
        logic center_next;
        logic row_load;
        logic read;
        logic row_next;
        logic emit;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic has_center;
        logic row_ok;
        logic j_last;
        logic row_last;
        logic c_last;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/diamond_window_sum_argmax_core.sv @@
// top level of the diamond window sum and argmax block
//
//  channel  direction  handshake                   payload
//  in       input      i_in_valid / o_in_ready      i_action, i_pixel_value
//  out      output     o_out_valid / i_out_ready    center row/col, sums, event, count, last
//  cfg      input      i_cfg_we                     i_cfg_idx, i_cfg_data
//
//  an item passes through accept and setup, then through the window walk of each of its centers
//  each center costs (2d+1) row setups, line store reads of its up to (2d*d+2d+1)
//  in-frame entries, a pass through the read state for each window row outside the frame,
//  and the drain and emit states, d being the radius; the single read port sets this
//  a row end walks up to d+1 centers back to back; a new transaction is taken once the
//  last result is loaded into the output register
//  reset is synchronous and needs no clearing pass; a stalled output holds the walk
`default_nettype none

module diamond_window_sum_argmax_core
    import dwsa_pkg::*;
#(
    parameter int MAX_COLS    = 1024,
    parameter int MAX_RADIUS  = 15,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [CFG_W-1:0]              i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_action,
    input  wire logic signed [SAMPLE_BITS-1:0] i_pixel_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [POS_W-1:0]                   o_center_row,
    output logic [POS_W-1:0]                   o_center_col,
    output logic signed [SUM_W-1:0]            o_window_sum,
    output logic [EV_W-1:0]                    o_max_event,
    output logic signed [SUM_W-1:0]            o_best_sum,
    output logic [CNT_W-1:0]                   o_best_count,
    output logic                               o_last
);
    t_cmd w_cmd;
    t_sts w_sts;

    dwsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    dwsa_dp #(
        .MAX_COLS    (MAX_COLS),
        .MAX_RADIUS  (MAX_RADIUS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_action),
        .i_pixel_value (i_pixel_value),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_center_row  (o_center_row),
        .o_center_col  (o_center_col),
        .o_window_sum  (o_window_sum),
        .o_max_event   (o_max_event),
        .o_best_sum    (o_best_sum),
        .o_best_count  (o_best_count),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

@@ rtl/dwsa_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module dwsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [AW-1:0]            i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [AW-1:0]            i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/dwsa_ctrl.sv @@
// sequencing state machine for one input transaction and its centers
`default_nettype none

module dwsa_ctrl
    import dwsa_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_ROW,
        S_READ,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) n_state = S_SETUP;
            end
            S_SETUP: begin
                if (i_sts.has_center) begin
                    o_cmd.center_init = 1'b1;
                    n_state = S_ROW;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ROW: begin
                o_cmd.row_load = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                o_cmd.read = i_sts.row_ok;
                if (!i_sts.row_ok || i_sts.j_last) begin
                    if (i_sts.row_last) begin
                        n_state = S_DRAIN;
                    end else begin
                        o_cmd.row_next = 1'b1;
                        n_state = S_ROW;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.c_last) begin
                        o_cmd.finish = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.center_next = 1'b1;
                        n_state = S_ROW;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ rtl/dwsa_dp.sv @@
// datapath: counters, line store, window accumulation, argmax and output register
`default_nettype none

module dwsa_dp
    import dwsa_pkg::*;
#(
    parameter int MAX_COLS    = 1024,
    parameter int MAX_RADIUS  = 15,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [CFG_W-1:0]              i_cfg_data,
    input  wire logic                          i_action,
    input  wire logic signed [SAMPLE_BITS-1:0] i_pixel_value,
    input  wire t_cmd                          i_cmd,
    output t_sts                               o_sts,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [POS_W-1:0]                   o_center_row,
    output logic [POS_W-1:0]                   o_center_col,
    output logic signed [SUM_W-1:0]            o_window_sum,
    output logic [EV_W-1:0]                    o_max_event,
    output logic signed [SUM_W-1:0]            o_best_sum,
    output logic [CNT_W-1:0]                   o_best_count,
    output logic                               o_last
);
    localparam int RING   = 2 * MAX_RADIUS + 1;
    localparam int DEPTH  = RING * MAX_COLS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CW     = $clog2(MAX_COLS + 1);
    localparam int RW     = $clog2(ROW_LIMIT + MAX_RADIUS + 1);
    localparam int SLOT_W = (RING > 1) ? $clog2(RING) : 1;
    localparam int RDW    = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int KW     = (RING > 1) ? $clog2(RING) : 1;
    localparam int SW     = RW + 2;
    localparam int ACC_W  = SAMPLE_BITS + $clog2(2 * MAX_RADIUS * (MAX_RADIUS + 1) + 2);

    // configuration
    logic [CFG_W-1:0]     r_rows, r_cols;
    logic [RAD_CFG_W-1:0] r_rad;
    logic [RW-1:0]        w_n;
    logic [CW-1:0]        w_m;
    logic [RDW-1:0]       w_d;

    // frame position
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic [SLOT_W-1:0] r_slot;

    // current transaction
    logic              r_has, r_frame_end;
    logic [CIDX_W-1:0] r_c, r_clast;
    logic [RW-1:0]     r_r;
    logic [SLOT_W-1:0] r_islot;

    // window walk
    logic [KW-1:0]           r_k;
    logic signed [SW-1:0]    r_i;
    logic [SLOT_W-1:0]       r_rslot;
    logic [CIDX_W-1:0]       r_j, r_hi;
    logic                    r_rd_pend;
    logic signed [ACC_W-1:0] r_acc;

    // running maximum
    logic signed [ACC_W-1:0] r_best;
    logic                    r_best_valid;
    logic [CNT_W-1:0]        r_cnt;

    logic                          w_we;
    logic [AW-1:0]                 w_waddr, w_raddr;
    logic signed [SAMPLE_BITS-1:0] w_wdata, w_rdata;
    logic                          w_has;
    logic [CIDX_W-1:0]             w_cfirst, w_clast, w_lo, w_hi;
    logic [SLOT_W-1:0]             w_slot0;
    logic                          w_row_ok;

    always_comb begin
        int v_m, v_d, v_row, v_col, v_cf, v_k, v_span, v_c, v_lo, v_hi, v_s;
        logic v_row_end;
        w_n = (r_rows == '0) ? RW'(1)
            : (int'(r_rows) > ROW_LIMIT) ? RW'(ROW_LIMIT) : RW'(r_rows);
        w_m = (r_cols == '0) ? CW'(1)
            : (int'(r_cols) > MAX_COLS) ? CW'(MAX_COLS) : CW'(r_cols);
        w_d = (int'(r_rad) > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(r_rad);
        v_m   = int'(w_m);
        v_d   = int'(w_d);
        v_row = int'(r_row);
        v_col = int'(r_col);
        v_row_end = (v_col == v_m - 1);
        w_has = (v_row >= v_d) && (v_row_end || v_col >= v_d);
        if (v_row_end) begin
            v_cf = (v_m - 1 - v_d < 0) ? 0 : v_m - 1 - v_d;
        end else begin
            v_cf = v_col - v_d;
        end
        w_cfirst = CIDX_W'(v_cf);
        w_clast  = v_row_end ? CIDX_W'(v_m - 1) : CIDX_W'(v_cf);
        v_s = int'(r_islot) - 2 * v_d;
        if (v_s < 0) v_s = v_s + RING;
        w_slot0 = SLOT_W'(v_s);
        v_k    = int'(r_k);
        v_span = (v_k > v_d) ? (2 * v_d - v_k) : v_k;
        v_c    = int'(r_c);
        v_lo   = (v_c - v_span < 0) ? 0 : v_c - v_span;
        v_hi   = (v_c + v_span > v_m - 1) ? v_m - 1 : v_c + v_span;
        w_lo   = CIDX_W'(v_lo);
        w_hi   = CIDX_W'(v_hi);
        w_row_ok = (int'(r_i) >= 0) && (int'(r_i) < int'(w_n));
    end

    assign w_we    = i_cmd.accept && (r_row < w_n);
    assign w_wdata = i_action ? '0 : i_pixel_value;
    assign w_waddr = AW'(r_slot) * AW'(MAX_COLS) + AW'(r_col);
    assign w_raddr = AW'(r_rslot) * AW'(MAX_COLS) + AW'(r_j);

    dwsa_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_sts.has_center = r_has;
    assign o_sts.row_ok     = w_row_ok;
    assign o_sts.j_last     = (r_j == r_hi);
    assign o_sts.row_last   = (int'(r_k) == 2 * int'(w_d));
    assign o_sts.c_last     = (r_c == r_clast);
    assign o_sts.out_free   = !o_out_valid || i_out_ready;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows       <= CFG_W'(1);
            r_cols       <= CFG_W'(1);
            r_rad        <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_slot       <= '0;
            r_frame_end  <= 1'b0;
            r_has        <= 1'b0;
            r_rd_pend    <= 1'b0;
            r_best_valid <= 1'b0;
            r_best       <= '0;
            r_cnt        <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.read;
            if (i_cfg_we && (i_cfg_idx == CFG_ROWS || i_cfg_idx == CFG_COLS
                             || i_cfg_idx == CFG_RADIUS)) begin
                unique case (i_cfg_idx)
                    CFG_ROWS:   r_rows <= i_cfg_data;
                    CFG_COLS:   r_cols <= i_cfg_data;
                    CFG_RADIUS: r_rad  <= i_cfg_data[RAD_CFG_W-1:0];
                    default:    r_rad  <= r_rad;
                endcase
                r_row        <= '0;
                r_col        <= '0;
                r_slot       <= '0;
                r_best_valid <= 1'b0;
                r_best       <= '0;
                r_cnt        <= '0;
            end
            if (i_cmd.accept) begin
                r_has       <= w_has;
                r_frame_end <= 1'b0;
                if (r_col + CW'(1) == w_m) begin
                    r_col <= '0;
                    if (int'(r_row) + 1 == int'(w_n) + int'(w_d)) begin
                        r_row       <= '0;
                        r_slot      <= '0;
                        r_frame_end <= 1'b1;
                    end else begin
                        r_row  <= r_row + RW'(1);
                        r_slot <= (int'(r_slot) == RING - 1) ? '0 : r_slot + SLOT_W'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (i_cmd.emit) begin
                o_out_valid <= 1'b1;
                if (!r_best_valid || r_acc > r_best) begin
                    r_best       <= r_acc;
                    r_best_valid <= 1'b1;
                    r_cnt        <= CNT_W'(1);
                end else if (r_acc == r_best && r_cnt != '1) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (i_cmd.finish && r_frame_end) begin
                r_best_valid <= 1'b0;
                r_best       <= '0;
                r_cnt        <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_c     <= w_cfirst;
            r_clast <= w_clast;
            r_r     <= RW'(int'(r_row) - int'(w_d));
            r_islot <= r_slot;
        end
        if (i_cmd.center_next) begin
            r_c <= r_c + CIDX_W'(1);
        end
        if (i_cmd.center_init || i_cmd.center_next) begin
            r_k     <= '0;
            r_i     <= SW'(int'(r_r) - int'(w_d));
            r_rslot <= w_slot0;
            r_acc   <= '0;
        end
        if (i_cmd.row_load) begin
            r_j  <= w_lo;
            r_hi <= w_hi;
        end
        if (i_cmd.read) begin
            r_j <= r_j + CIDX_W'(1);
        end
        if (i_cmd.row_next) begin
            r_k     <= r_k + KW'(1);
            r_i     <= r_i + SW'(1);
            r_rslot <= (int'(r_rslot) == RING - 1) ? '0 : r_rslot + SLOT_W'(1);
        end
        if (r_rd_pend) begin
            r_acc <= r_acc + ACC_W'(w_rdata);
        end
        if (i_cmd.emit) begin
            o_center_row <= POS_W'(int'(r_r) + 1);
            o_center_col <= POS_W'(int'(r_c) + 1);
            o_window_sum <= SUM_W'(r_acc);
            o_last       <= o_sts.c_last;
            if (!r_best_valid || r_acc > r_best) begin
                o_max_event  <= EV_NEW;
                o_best_sum   <= SUM_W'(r_acc);
                o_best_count <= CNT_W'(1);
            end else if (r_acc == r_best) begin
                o_max_event  <= EV_TIE;
                o_best_sum   <= SUM_W'(r_best);
                o_best_count <= (r_cnt == '1) ? r_cnt : r_cnt + CNT_W'(1);
            end else begin
                o_max_event  <= EV_BELOW;
                o_best_sum   <= SUM_W'(r_best);
                o_best_count <= r_cnt;
            end
        end
    end

    a_read_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.read |-> w_row_ok)
        else $error("line store read outside frame rows");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("result overwrites a pending transaction");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_best_count != '0))
        else $error("result with empty maximum list");

    a_no_read_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> !i_cmd.read && !r_rd_pend)
        else $error("window walk overlaps a new transaction");

endmodule

`default_nettype wire

@@ verif/tb_diamond_window_sum_argmax_core.sv @@
// testbench for the diamond window sum and argmax core: directed table then random frames
`default_nettype none

module tb_diamond_window_sum_argmax_core;
    import dwsa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_RADIUS = 15;
    localparam int RING_ROWS  = 2 * MAX_RADIUS + 1;
    localparam int RAND_ITEMS = 370;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic signed [SUM_W-1:0] wsum;
        logic [EV_W-1:0]         ev;
        logic signed [SUM_W-1:0] best;
        logic [CNT_W-1:0]        cnt;
        logic                    last;
    } center_result_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        bit                   act;
        logic signed [15:0]   pix;
        bit                   typed;
    } stim_row_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic                    i_action = 1'b0;
    logic signed [15:0]      i_pixel_value = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic [POS_W-1:0]        o_center_row;
    logic [POS_W-1:0]        o_center_col;
    logic signed [SUM_W-1:0] o_window_sum;
    logic [EV_W-1:0]         o_max_event;
    logic signed [SUM_W-1:0] o_best_sum;
    logic [CNT_W-1:0]        o_best_count;
    logic                    o_last;

    diamond_window_sum_argmax_core dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    int          samples [RING_ROWS][MAX_COLS];
    int unsigned rows_reg = 1, cols_reg = 1, radius_reg = 0;
    int unsigned row_pos, col_pos, tie_cnt;
    longint      best_val;
    bit          best_ok;

    center_result_t expected_centers[$];
    center_result_t fresh[$];
    int  errors = 0;
    int  send_idle_pct = 13;
    int  recv_idle_pct = 49;

    function automatic int clamp_sz(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic void clear_frame();
        row_pos = 0;
        col_pos = 0;
        best_val = 0;
        best_ok = 0;
        tie_cnt = 0;
    endfunction

    function automatic longint diamond_total(int r, int c, int n, int m, int d);
        longint acc;
        int span;
        acc = 0;
        for (int dr = -d; dr <= d; dr++) begin
            span = d - ((dr < 0) ? -dr : dr);
            if (r + dr < 0 || r + dr >= n) continue;
            for (int j = c - span; j <= c + span; j++) begin
                if (j < 0 || j >= m) continue;
                acc += samples[(r + dr) % RING_ROWS][j];
            end
        end
        return acc;
    endfunction

    // fills fresh with the centers completed by this transaction
    function automatic void predict_centers(bit act, logic signed [15:0] pix);
        int n, m, d, r, c0, c1;
        longint s;
        center_result_t res;
        n = clamp_sz(rows_reg, ROW_LIMIT);
        m = clamp_sz(cols_reg, MAX_COLS);
        d = radius_reg;
        fresh.delete();
        if (col_pos >= m) col_pos = 0;
        if (row_pos >= n + d) row_pos = 0;
        if (row_pos < n) samples[row_pos % RING_ROWS][col_pos] = act ? 0 : int'(pix);
        if (row_pos >= d) begin
            r = row_pos - d;
            if (col_pos == m - 1) begin
                c0 = (m - 1 - d < 0) ? 0 : m - 1 - d;
                c1 = m - 1;
            end else begin
                c0 = int'(col_pos) - d;
                c1 = c0;
            end
            for (int c = c0; c <= c1; c++) begin
                if (c < 0) continue;
                s = diamond_total(r, c, n, m, d);
                if (!best_ok || s > best_val) begin
                    best_val = s;
                    best_ok = 1;
                    tie_cnt = 1;
                    res.ev = EV_NEW;
                end else if (s == best_val) begin
                    if (tie_cnt < (1 << CNT_W) - 1) tie_cnt++;
                    res.ev = EV_TIE;
                end else begin
                    res.ev = EV_BELOW;
                end
                res.row = POS_W'(r + 1);
                res.col = POS_W'(c + 1);
                res.wsum = s[SUM_W-1:0];
                res.best = best_val[SUM_W-1:0];
                res.cnt = CNT_W'(tie_cnt);
                res.last = 0;
                fresh.push_back(res);
            end
            if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1;
        end
        col_pos++;
        if (col_pos >= m) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= n + d) clear_frame();
        end
    endfunction

    task automatic send_transaction(bit act, logic signed [15:0] pix, bit typed);
        center_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_pixel_value <= pix;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_centers(act, pix);
        if (typed) begin
            res.row = 1;
            res.col = 1;
            res.wsum = act ? 0 : pix;
            res.ev = EV_NEW;
            res.best = res.wsum;
            res.cnt = 1;
            res.last = 1;
            expected_centers.push_back(res);
        end else begin
            foreach (fresh[k]) expected_centers.push_back(fresh[k]);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_centers.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ROWS:   rows_reg = data;
            CFG_COLS:   cols_reg = data;
            CFG_RADIUS: radius_reg = data[RAD_CFG_W-1:0];
            default:    ;
        endcase
        if (idx != CFG_SPARE) clear_frame();
    endtask

    function automatic logic signed [15:0] rand_pixel();
        case ($urandom_range(7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            default: return 16'($urandom());
        endcase
    endfunction

    // output checker
    always @(posedge i_clk) begin
        center_result_t e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_centers.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected transaction row %0d col %0d",
                                               o_center_row, o_center_col);
                end else begin
                    e = expected_centers.pop_front();
                    if (o_center_row !== e.row || o_center_col !== e.col ||
                        o_window_sum !== e.wsum || o_max_event !== e.ev ||
                        o_best_sum !== e.best || o_best_count !== e.cnt ||
                        o_last !== e.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp %0d/%0d sum %0d ev %0d best %0d cnt %0d last %0d %s",
                                     e.row, e.col, e.wsum, e.ev, e.best, e.cnt, e.last,
                                     $sformatf("got %0d/%0d sum %0d ev %0d best %0d cnt %0d last %0d",
                                               o_center_row, o_center_col, o_window_sum,
                                               o_max_event, o_best_sum, o_best_count, o_last));
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #100_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        stim_row_t table_rows[$];
        int n, m, d, frame_len, sent;
        bit act;

        clear_frame();
        table_rows = '{
            '{1, CFG_ROWS,   11'd0,    0, 16'sd0,     0},
            '{1, CFG_COLS,   11'd0,    0, 16'sd0,     0},
            '{1, CFG_RADIUS, 11'd0,    0, 16'sd0,     0},
            '{0, CFG_ROWS,   11'd0,    0, 16'sh7fff,  1},
            '{0, CFG_ROWS,   11'd0,    0, 16'sh8000,  1},
            '{0, CFG_ROWS,   11'd0,    0, 16'sd0,     1},
            '{0, CFG_ROWS,   11'd0,    0, -16'sd1,    1},
            '{0, CFG_ROWS,   11'd0,    1, 16'sh1234,  1},
            '{0, CFG_ROWS,   11'd0,    0, 16'sh5555,  1},
            '{1, CFG_RADIUS, 11'd2,    0, 16'sd0,     0},
            '{0, CFG_ROWS,   11'd0,    0, -16'sd5,    0},
            '{0, CFG_ROWS,   11'd0,    1, 16'sd0,     0},
            '{0, CFG_ROWS,   11'd0,    0, 16'sh2aaa,  0},
            '{1, CFG_SPARE,  11'd5,    0, 16'sd0,     0},
            '{1, CFG_ROWS,   11'd2,    0, 16'sd0,     0},
            '{1, CFG_COLS,   11'd2,    0, 16'sd0,     0},
            '{1, CFG_RADIUS, 11'd1,    0, 16'sd0,     0},
            '{0, CFG_ROWS,   11'd0,    0, 16'sd7,     0},
            '{0, CFG_ROWS,   11'd0,    1, 16'sd3,     0},
            '{0, CFG_ROWS,   11'd0,    0, 16'sh7fff,  0},
            '{0, CFG_ROWS,   11'd0,    0, 16'sh7fff,  0},
            '{0, CFG_ROWS,   11'd0,    0, -16'sd9,    0},
            '{0, CFG_ROWS,   11'd0,    1, 16'sd1,     0},
            '{1, CFG_ROWS,   11'd2047, 0, 16'sd0,     0},
            '{1, CFG_COLS,   11'd2047, 0, 16'sd0,     0},
            '{1, CFG_RADIUS, 11'd15,   0, 16'sd0,     0},
            '{0, CFG_ROWS,   11'd0,    0, 16'sh8000,  0},
            '{0, CFG_ROWS,   11'd0,    0, 16'sh7fff,  0},
            '{0, CFG_ROWS,   11'd0,    1, 16'sd0,     0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_rows[k]) begin
            if (table_rows[k].is_cfg) write_reg(table_rows[k].idx, table_rows[k].data);
            else send_transaction(table_rows[k].act, table_rows[k].pix, table_rows[k].typed);
        end

        sent = 0;
        while (sent < RAND_ITEMS) begin
            if ($urandom_range(4) == 0) begin
                write_reg(CFG_ROWS, CFG_W'($urandom_range(1, 2)));
                write_reg(CFG_COLS, CFG_W'($urandom_range(1, 3)));
                write_reg(CFG_RADIUS, CFG_W'($urandom_range(4, 15)));
            end else begin
                write_reg(CFG_ROWS, CFG_W'($urandom_range(1, 6)));
                write_reg(CFG_COLS, CFG_W'($urandom_range(1, 8)));
                write_reg(CFG_RADIUS, CFG_W'($urandom_range(0, 3)));
            end
            n = rows_reg;
            m = cols_reg;
            d = radius_reg;
            repeat ($urandom_range(1, 2)) begin
                frame_len = (n + d) * m;
                // some frames are cut short and restarted by the next register write
                if ($urandom_range(9) == 0) frame_len = $urandom_range(1, frame_len);
                for (int k = 0; k < frame_len; k++) begin
                    if (sent < RAND_ITEMS / 3) begin
                        send_idle_pct = 13;
                        recv_idle_pct = 49;
                    end else if (sent < 2 * RAND_ITEMS / 3) begin
                        send_idle_pct = 49;
                        recv_idle_pct = 13;
                    end else begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                    if (k < n * m) act = ($urandom_range(9) == 0);
                    else act = ($urandom_range(9) != 0);
                    send_transaction(act, rand_pixel(), 0);
                    sent++;
                end
            end
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_centers.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/dwsa_pkg.sv
rtl/dwsa_ram.sv
rtl/dwsa_ctrl.sv
rtl/dwsa_dp.sv
rtl/diamond_window_sum_argmax_core.sv
verif/tb_diamond_window_sum_argmax_core.sv
